FILE: design/vdd_pkg.sv
// Shared types and constants for the varint delta vertex decoder.
package vdd_pkg;

    // Default configuration of the decoder.
    localparam int MAX_VARINT_BYTES_DEF = 10;
    localparam int VALUE_BITS_DEF       = 53;
    localparam int COORD_BITS_DEF       = 32;

    // Fixed port and internal widths.
    localparam int BYTE_W      = 8;
    localparam int OUT_COORD_W = 32;
    localparam int CNT_W       = 4;
    localparam int SHAMT_W     = 7;
    localparam int CURSOR_W    = 64;

    // Result codes.
    typedef enum logic [1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_TOO_LONG = 2'd2,
        KIND_RANGE    = 2'd3
    } vdd_kind_t;

    // Parser phase, one-hot.
    typedef enum logic [3:0] {
        PH_COUNT = 4'b0001,
        PH_U     = 4'b0010,
        PH_V     = 4'b0100,
        PH_HALT  = 4'b1000
    } vdd_phase_t;

    // Status of the varint unit for the byte being processed.
    typedef struct packed {
        logic too_long;
        logic done;
        logic out_of_range;
    } vdd_status_t;

endpackage

FILE: design/vdd_varint.sv
// LEB128 varint accumulator with length and range checks.
module vdd_varint #(
    parameter int MAX_VARINT_BYTES = vdd_pkg::MAX_VARINT_BYTES_DEF,
    parameter int VALUE_BITS       = vdd_pkg::VALUE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       restart,
    input  logic [vdd_pkg::BYTE_W-1:0] data_byte,
    output vdd_pkg::vdd_status_t       status,
    output logic [VALUE_BITS-1:0]      value
);
    import vdd_pkg::*;

    // The shifted payload must cover every byte position and one bit above the value.
    localparam int SPAN = 7 * MAX_VARINT_BYTES;
    localparam int WIDE = (SPAN > VALUE_BITS) ? SPAN : VALUE_BITS + 1;

    logic [CNT_W-1:0]      cnt_reg, cnt_next, cnt_eff;
    logic [VALUE_BITS-1:0] acc_reg, acc_next, acc_eff, acc_upd;
    logic                  ovf_reg, ovf_next, ovf_eff, ovf_upd;
    logic [SHAMT_W-1:0]    shamt;
    logic [WIDE-1:0]       shifted;

    // A geometry start drops any partial varint before this byte acts.
    always_comb
    begin
        cnt_eff = restart ? '0 : cnt_reg;
        acc_eff = restart ? '0 : acc_reg;
        ovf_eff = restart ? 1'b0 : ovf_reg;
    end

    // Place the payload at bit 7*k and check for bits past the value width.
    always_comb
    begin
        shamt   = (SHAMT_W'(cnt_eff) << 3) - SHAMT_W'(cnt_eff);
        shifted = WIDE'(data_byte[6:0]) << shamt;
        acc_upd = acc_eff | shifted[VALUE_BITS-1:0];
        ovf_upd = ovf_eff | (|shifted[WIDE-1:VALUE_BITS]);
    end

    // Status toward the parser.
    always_comb
    begin
        status.too_long     = (cnt_eff >= CNT_W'(MAX_VARINT_BYTES));
        status.done         = !status.too_long && !data_byte[7];
        status.out_of_range = status.done && ovf_upd;
        value               = acc_upd;
    end

    // A finished or rejected varint leaves the unit empty.
    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        if (step)
        begin
            if (status.too_long || status.done)
            begin
                cnt_next = '0;
                acc_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_eff + CNT_W'(1);
                acc_next = acc_upd;
                ovf_next = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

FILE: design/varint_delta_vertex_decoder_top.sv
// Top level of the varint delta vertex decoder.
//
// The input channel carries one stream byte per transfer, with geometry_start
// marking the first byte of a vertex count and cursor_clear returning the
// cursor to the origin before that byte acts. Each geometry is a LEB128 count
// followed by zigzag LEB128 u and v deltas for every vertex.
// The output channel carries at most one result per input byte: a vertex with
// its last flag, an empty geometry, or an error (varint too long or out of
// range). After an error the decoder ignores bytes until a geometry start.
// An accepted byte is registered in the input register; when it advances, its
// result is loaded into the output register, from which the result transfer
// takes it when out_stall is low.
// One byte is taken every cycle while the receiver does not stall: the varint
// shift and the cursor add are combinational logic between the two registers.
// When the receiver stalls, the output register holds its result and the input
// register holds one further byte; in_stall rises only when both are full.
// Reset empties both registers, zeros the cursor and starts in the count phase.
module varint_delta_vertex_decoder_top #(
    parameter int MAX_VARINT_BYTES = vdd_pkg::MAX_VARINT_BYTES_DEF,
    parameter int VALUE_BITS       = vdd_pkg::VALUE_BITS_DEF,
    parameter int COORD_BITS       = vdd_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [vdd_pkg::BYTE_W-1:0]             data_byte,
    input  logic                                   geometry_start,
    input  logic                                   cursor_clear,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [1:0]                             result_kind,
    output logic signed [vdd_pkg::OUT_COORD_W-1:0] vertex_u,
    output logic signed [vdd_pkg::OUT_COORD_W-1:0] vertex_v,
    output logic                                   last_vertex
);
    import vdd_pkg::*;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              start_reg;
    logic              clear_reg;

    // Parser state.
    vdd_phase_t            phase_reg, phase_next, phase_eff;
    logic [VALUE_BITS-1:0] left_reg, left_next, left_eff, left_dec;
    logic [COORD_BITS-1:0] cur_u_reg, cur_u_next, cur_u_eff, cur_u_sum;
    logic [COORD_BITS-1:0] cur_v_reg, cur_v_next, cur_v_eff, cur_v_sum;
    logic [COORD_BITS-1:0] pend_u_reg, pend_u_next;

    // Output register.
    logic                   out_valid_reg;
    vdd_kind_t              kind_reg, kind_next;
    logic [OUT_COORD_W-1:0] u_reg, u_next, v_reg, v_next;
    logic                   last_reg, last_next;

    logic                  advance;
    logic                  step;
    logic                  fire;
    vdd_status_t           vstat;
    logic [VALUE_BITS-1:0] vvalue;
    logic [CURSOR_W-1:0]   zz_wide, unz_wide, u_ext, v_ext;
    logic [COORD_BITS-1:0] delta;

    // The input register moves on whenever the output register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg  <= data_byte;
            start_reg <= geometry_start;
            clear_reg <= cursor_clear;
        end
    end

    // Start and clear marks take effect before the byte is decoded.
    always_comb
    begin
        phase_eff = start_reg ? PH_COUNT : phase_reg;
        left_eff  = start_reg ? '0 : left_reg;
        cur_u_eff = clear_reg ? '0 : cur_u_reg;
        cur_v_eff = clear_reg ? '0 : cur_v_reg;
    end

    assign step = advance && (phase_eff != PH_HALT);

    vdd_varint #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
        .VALUE_BITS       (VALUE_BITS)
    ) u_varint (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .restart   (start_reg),
        .data_byte (byte_reg),
        .status    (vstat),
        .value     (vvalue)
    );

    // Zigzag decode; only the low coordinate bits reach the cursor.
    always_comb
    begin
        zz_wide   = CURSOR_W'(vvalue);
        unz_wide  = zz_wide[0] ? ~(zz_wide >> 1) : (zz_wide >> 1);
        delta     = unz_wide[COORD_BITS-1:0];
        cur_u_sum = cur_u_eff + pend_u_reg;
        cur_v_sum = cur_v_eff + delta;
        left_dec  = left_eff - VALUE_BITS'(1);
        u_ext     = CURSOR_W'(signed'(cur_u_sum));
        v_ext     = CURSOR_W'(signed'(cur_v_sum));
    end

    // Parser phase sequencing and result selection.
    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        pend_u_next = pend_u_reg;
        cur_u_next  = cur_u_reg;
        cur_v_next  = cur_v_reg;
        fire        = 1'b0;
        kind_next   = KIND_VERTEX;
        u_next      = '0;
        v_next      = '0;
        last_next   = 1'b0;
        if (advance)
        begin
            phase_next = phase_eff;
            left_next  = left_eff;
            cur_u_next = cur_u_eff;
            cur_v_next = cur_v_eff;
        end
        if (step)
        begin
            if (vstat.too_long)
            begin
                phase_next = PH_HALT;
                fire       = 1'b1;
                kind_next  = KIND_TOO_LONG;
            end
            else if (vstat.out_of_range)
            begin
                phase_next = PH_HALT;
                fire       = 1'b1;
                kind_next  = KIND_RANGE;
            end
            else if (vstat.done)
            begin
                unique case (phase_eff)
                    PH_COUNT:
                    begin
                        if (vvalue == '0)
                        begin
                            fire      = 1'b1;
                            kind_next = KIND_EMPTY;
                        end
                        else
                        begin
                            left_next  = vvalue;
                            phase_next = PH_U;
                        end
                    end
                    PH_U:
                    begin
                        pend_u_next = delta;
                        phase_next  = PH_V;
                    end
                    PH_V:
                    begin
                        cur_u_next = cur_u_sum;
                        cur_v_next = cur_v_sum;
                        left_next  = left_dec;
                        phase_next = (left_dec != '0) ? PH_U : PH_COUNT;
                        fire       = 1'b1;
                        kind_next  = KIND_VERTEX;
                        u_next     = u_ext[OUT_COORD_W-1:0];
                        v_next     = v_ext[OUT_COORD_W-1:0];
                        last_next  = (left_dec == '0);
                    end
                    default:
                    begin
                        phase_next = PH_HALT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_COUNT;
            left_reg   <= '0;
            cur_u_reg  <= '0;
            cur_v_reg  <= '0;
            pend_u_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            cur_u_reg  <= cur_u_next;
            cur_v_reg  <= cur_v_next;
            pend_u_reg <= pend_u_next;
        end
    end

    // Output register: loaded on every advance, cleared once a transfer drains it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg <= kind_next;
            u_reg    <= u_next;
            v_reg    <= v_next;
            last_reg <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign vertex_u    = u_reg;
    assign vertex_v    = v_reg;
    assign last_vertex = last_reg;

endmodule

FILE: tb/sv/varint_delta_vertex_decoder_top_tb.sv
// Self-checking testbench for the varint delta vertex decoder top level.
`timescale 1ns / 100ps

module varint_delta_vertex_decoder_top_tb;
    import vdd_pkg::*;

    localparam int MAX_BYTES    = MAX_VARINT_BYTES_DEF;
    localparam int VALUE_BITS   = VALUE_BITS_DEF;
    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int ITEM_TARGET  = 1300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTS   = 40;
    localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;

    // One stream byte, with an optional hand-written expectation.
    typedef struct packed {
        logic [BYTE_W-1:0]        data;
        logic                     gs;
        logic                     cc;
        logic                     typed_exp;
        logic                     fx_res;
        vdd_kind_t                fx_kind;
        logic signed [31:0]       fx_u;
        logic signed [31:0]       fx_v;
        logic                     fx_last;
    } byte_item_t;

    // One decoded result as it leaves the block.
    typedef struct packed {
        vdd_kind_t                kind;
        logic signed [31:0]       u;
        logic signed [31:0]       v;
        logic                     last;
    } result_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH,
        IDLE_PRESSURE
    } idle_mode_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [BYTE_W-1:0]               data_byte;
    logic                            geometry_start;
    logic                            cursor_clear;
    logic                            out_valid;
    logic                            out_stall;
    logic [1:0]                      result_kind;
    logic signed [OUT_COORD_W-1:0]   vertex_u;
    logic signed [OUT_COORD_W-1:0]   vertex_v;
    logic                            last_vertex;

    // Decoder state as predicted by the testbench.
    logic [63:0] cur_u;
    logic [63:0] cur_v;
    logic [63:0] acc_value;
    bit          acc_ovf;
    int          acc_bytes;
    vdd_phase_t  walk_phase;
    logic [63:0] verts_left;
    logic [63:0] u_delta_hold;

    byte_item_t  byte_stream_q [$];
    result_t     pending_results [$];
    int          bytes_queued;
    int          bytes_accepted;
    int          useful_cnt;
    int          fail_cnt;
    int          cycle_cnt;
    int          send_idle_pct;
    int          stall_pct;
    bit          pressure_req;
    idle_mode_t  idle_mode;

    // Directed stream: empty geometry, vertices, padding, too long, halt, out of range.
    byte_item_t dir_rows [0:27] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, KIND_EMPTY,    32'sd0,  32'sd0, 1'b0},
        '{8'h01, 1'b1, 1'b0, 1'b1, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h02, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h02, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, KIND_TOO_LONG, 32'sd0,  32'sd0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 1'b1, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_VERTEX,   32'sd0,  32'sd0, 1'b0},
        '{8'h10, 1'b0, 1'b0, 1'b1, 1'b1, KIND_RANGE,    32'sd0,  32'sd0, 1'b0}
    };

    varint_delta_vertex_decoder_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .geometry_start (geometry_start),
        .cursor_clear   (cursor_clear),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .vertex_u       (vertex_u),
        .vertex_v       (vertex_v),
        .last_vertex    (last_vertex)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Undo the zigzag mapping of a delta.
    function automatic logic [63:0] unzigzag(input logic [63:0] z);
        return z[0] ? ~(z >> 1) : (z >> 1);
    endfunction

    // Low COORD_BITS of the cursor, sign-extended to the port width.
    function automatic logic signed [31:0] to_coord(input logic [63:0] c);
        logic signed [63:0] t;
        t = $signed(c << (64 - COORD_BITS)) >>> (64 - COORD_BITS);
        return t[31:0];
    endfunction

    task automatic clear_varint();
        acc_value = '0;
        acc_ovf   = 1'b0;
        acc_bytes = 0;
    endtask

    // Advance the predicted decoder by one byte and return the result it causes.
    task automatic decode_byte(input byte_item_t it, output bit has_res,
                               output result_t res, output bit ignored);
        logic [63:0] payload;
        logic [63:0] value;
        int          shamt;
        payload = {57'd0, it.data[6:0]};
        has_res = 1'b0;
        ignored = 1'b0;
        res     = '0;
        if (it.cc)
        begin
            cur_u = '0;
            cur_v = '0;
        end
        if (it.gs)
        begin
            walk_phase = PH_COUNT;
            verts_left = '0;
            clear_varint();
        end
        if (walk_phase == PH_HALT)
        begin
            ignored = 1'b1;
            return;
        end

        // Too long: the byte past the limit fails whatever its continuation bit.
        if (acc_bytes + 1 > MAX_BYTES)
        begin
            clear_varint();
            walk_phase = PH_HALT;
            has_res    = 1'b1;
            res.kind   = KIND_TOO_LONG;
            return;
        end
        shamt     = 7 * acc_bytes;
        acc_bytes = acc_bytes + 1;
        if (shamt >= VALUE_BITS)
        begin
            if (payload != 0)
                acc_ovf = 1'b1;
        end
        else
        begin
            if ((payload >> (VALUE_BITS - shamt)) != 0)
                acc_ovf = 1'b1;
            acc_value = (acc_value | (payload << shamt)) & VALUE_MASK;
        end
        if (it.data[7])
            return;

        // The varint is complete.
        value = acc_value;
        if (acc_ovf)
        begin
            clear_varint();
            walk_phase = PH_HALT;
            has_res    = 1'b1;
            res.kind   = KIND_RANGE;
            return;
        end
        clear_varint();
        case (walk_phase)
            PH_COUNT:
            begin
                if (value == 0)
                begin
                    has_res  = 1'b1;
                    res.kind = KIND_EMPTY;
                end
                else
                begin
                    verts_left = value;
                    walk_phase = PH_U;
                end
            end
            PH_U:
            begin
                u_delta_hold = unzigzag(value);
                walk_phase   = PH_V;
            end
            default:
            begin
                cur_u      = cur_u + u_delta_hold;
                cur_v      = cur_v + unzigzag(value);
                verts_left = (verts_left - 64'd1) & VALUE_MASK;
                walk_phase = (verts_left != 0) ? PH_U : PH_COUNT;
                has_res    = 1'b1;
                res.kind   = KIND_VERTEX;
                res.u      = to_coord(cur_u);
                res.v      = to_coord(cur_v);
                res.last   = (verts_left == 0);
            end
        endcase
    endtask

    // Record an accepted byte and queue what it should produce.
    task automatic accept_byte(input byte_item_t it);
        bit      has_res;
        bit      ignored;
        result_t res;
        decode_byte(it, has_res, res, ignored);
        bytes_accepted++;
        if (!ignored)
            useful_cnt++;
        if (it.typed_exp)
        begin
            has_res  = it.fx_res;
            res.kind = it.fx_kind;
            res.u    = it.fx_u;
            res.v    = it.fx_v;
            res.last = it.fx_last;
        end
        if (has_res)
            pending_results.insert(pending_results.size(), res);
    endtask

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Compare one result transfer with the oldest expectation.
    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result kind %0d with nothing expected", result_kind));
            return;
        end
        want = pending_results.pop_front();
        if (result_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", result_kind, want.kind));
        if (vertex_u !== want.u)
            report_mismatch($sformatf("vertex_u %0d, expected %0d", vertex_u, want.u));
        if (vertex_v !== want.v)
            report_mismatch($sformatf("vertex_v %0d, expected %0d", vertex_v, want.v));
        if (last_vertex !== want.last)
            report_mismatch($sformatf("last_vertex %0b, expected %0b", last_vertex, want.last));
    endtask

    task automatic push_byte(input logic [7:0] b, input logic gs);
        byte_item_t it;
        it      = '0;
        it.data = b;
        it.gs   = gs;
        it.cc   = ($urandom_range(0, 23) == 0);
        byte_stream_q.insert(byte_stream_q.size(), it);
        bytes_queued++;
    endtask

    // LEB128 encoding over a chosen number of bytes; extra bytes pad with zero payload.
    task automatic push_varint(input logic [63:0] value, input int nbytes, input logic gs);
        logic [63:0] rest;
        rest = value;
        for (int i = 0; i < nbytes; i++)
        begin
            push_byte({(i < nbytes - 1), rest[6:0]}, gs && (i == 0));
            rest = rest >> 7;
        end
    endtask

    // Shortest encoding length, sometimes padded up to the byte limit.
    function automatic int varint_len(input logic [63:0] value);
        int n;
        n = 1;
        while (n < MAX_BYTES && (value >> (7 * n)) != 0)
            n++;
        if ($urandom_range(0, 7) == 0)
            n = $urandom_range(n, MAX_BYTES);
        return n;
    endfunction

    function automatic logic [63:0] rand_bits(input int width);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (width < 64)
            v = v & ((64'd1 << width) - 64'd1);
        return v;
    endfunction

    // Delta value: mostly short, sometimes up to the full value width.
    function automatic logic [63:0] rand_delta();
        if ($urandom_range(0, 3) == 0)
            return rand_bits($urandom_range(0, VALUE_BITS));
        return rand_bits($urandom_range(0, 14));
    endfunction

    // Append one geometry: mostly well formed, the rest errors and noise.
    task automatic gen_geometry();
        int          sel;
        int          pick;
        int          n_vert;
        logic [63:0] count;
        logic [63:0] v;
        bit          mark;
        sel  = $urandom_range(0, 99);
        mark = ($urandom_range(0, 9) != 0);
        if (sel < 78)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                count = 0;
            else if (pick < 16)
                count = $urandom_range(1, 4);
            else if (pick < 19)
                count = $urandom_range(5, 12);
            else
                count = rand_bits(VALUE_BITS);
            n_vert = (count > 12) ? $urandom_range(0, 3) : int'(count);
            // A geometry cut short by the next start mark.
            if ($urandom_range(0, 19) == 0)
                n_vert = $urandom_range(0, n_vert);
            push_varint(count, varint_len(count), mark);
            for (int i = 0; i < n_vert; i++)
            begin
                v = rand_delta();
                push_varint(v, varint_len(v), 1'b0);
                v = rand_delta();
                push_varint(v, varint_len(v), 1'b0);
            end
        end
        else if (sel < 86)
        begin
            // Payload bits at or above the value width, as count or as a delta.
            v = rand_bits(64) | (64'd1 << $urandom_range(VALUE_BITS, 63));
            if ($urandom_range(0, 1) == 0)
            begin
                push_varint(v, varint_len(v), mark);
            end
            else
            begin
                push_varint(64'd1, 1, mark);
                push_varint(v, varint_len(v), 1'b0);
            end
            push_byte($urandom_range(0, 255), 1'b0);
        end
        else if (sel < 92)
        begin
            v = rand_bits($urandom_range(0, 64));
            push_varint(v, $urandom_range(MAX_BYTES + 1, MAX_BYTES + 3), mark);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                push_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
        end
    endtask

    // Sender: offers bytes from the stream queue and holds them while stalled.
    initial
    begin
        byte_item_t cur;
        in_valid       <= 1'b0;
        data_byte      <= '0;
        geometry_start <= 1'b0;
        cursor_clear   <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
                accept_byte(cur);
            if (!(in_valid && in_stall))
            begin
                if (byte_stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur = byte_stream_q.pop_front();
                    data_byte      <= cur.data;
                    geometry_start <= cur.gs;
                    cursor_clear   <= cur.cc;
                    in_valid       <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (pressure_req)
            begin
                pressure_req = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_stall   <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Result monitor.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Reset, stimulus phases and end of run.
    initial
    begin
        idle_mode_t mode;
        cur_u          = '0;
        cur_v          = '0;
        verts_left     = '0;
        u_delta_hold   = '0;
        walk_phase     = PH_COUNT;
        clear_varint();
        bytes_queued   = 0;
        bytes_accepted = 0;
        useful_cnt     = 0;
        fail_cnt       = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        pressure_req   = 1'b0;
        idle_mode      = IDLE_NONE;
        rst_n          = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            byte_stream_q.insert(byte_stream_q.size(), dir_rows[i]);
            bytes_queued++;
        end

        // Random geometries, switching the idling pattern every hundred useful (not ignored) bytes.
        while (useful_cnt < ITEM_TARGET)
        begin
            if (byte_stream_q.size() > 24)
            begin
                @(posedge clk);
            end
            else
            begin
                mode = idle_mode_t'((useful_cnt / 100) % 5);
                if (mode != idle_mode)
                begin
                    idle_mode = mode;
                    case (mode)
                        IDLE_SENDER:
                        begin
                            send_idle_pct = 68;
                            stall_pct     = 0;
                        end
                        IDLE_RECEIVER:
                        begin
                            send_idle_pct = 0;
                            stall_pct     = 68;
                        end
                        IDLE_BOTH:
                        begin
                            send_idle_pct = 19;
                            stall_pct     = 19;
                        end
                        IDLE_PRESSURE:
                        begin
                            send_idle_pct = 0;
                            stall_pct     = 0;
                            pressure_req  = 1'b1;
                        end
                        default:
                        begin
                            send_idle_pct = 0;
                            stall_pct     = 0;
                        end
                    endcase
                end
                gen_geometry();
            end
        end

        // Drain: every byte taken, every result seen, then a short quiet period.
        while (bytes_accepted != bytes_queued)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/vdd_pkg.sv
design/vdd_varint.sv
design/varint_delta_vertex_decoder_top.sv
tb/sv/varint_delta_vertex_decoder_top_tb.sv
